// ===== design/gbip_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbip_pkg
// Shared constants and types for the GF(2) block inner product.
// ----------------------------------------------------------------------------
package gbip_pkg;

  // Rows of the block (and bits used in each row), 8 to 64.
  localparam int unsigned BlockWidth = 64;
  // Width of the row fields on the ports.
  localparam int unsigned RowW       = 64;
  // Width of the product index port.
  localparam int unsigned IndexW     = 6;
  // Width of the drain counter.
  localparam int unsigned IdxW       = $clog2(BlockWidth);

  typedef enum logic [0:0] {
    ST_ACCUM = 1'b0,
    ST_DRAIN = 1'b1
  } state_e;

  // Controls broadcast from the sequencer to every cell.
  typedef struct packed {
    logic acc_en;    // XOR the right row in where the cell's left bit is set
    logic shift_en;  // take the neighbor's row
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/gf2_block_inner_product_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gf2_block_inner_product_top
// GF(2) product V-transpose times W over a stream of row pairs, held in a
// chain of accumulator-row cells.
// ----------------------------------------------------------------------------
// Throughput: one row pair per cycle while busy_o is low.
// Order: the transfer marked last_row_i is accumulated at its own edge; the
//   64 product rows then follow, one per cycle, row 0 first.
// busy_o stays high while the product rows drain; the receiver cannot stall
//   the drain.
// Reset clears all accumulator rows at once; the drain also leaves them clear.
// ----------------------------------------------------------------------------
module gf2_block_inner_product_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [gbip_pkg::RowW-1:0]     left_row_i,
  input  wire logic [gbip_pkg::RowW-1:0]     right_row_i,
  input  wire logic                          last_row_i,
  output logic                               product_valid_o,
  output logic [gbip_pkg::IndexW-1:0]        product_index_o,
  output logic [gbip_pkg::RowW-1:0]          product_row_o,
  output logic                               final_row_o
);

  gbip_pkg::cell_ctrl_t              ctrl;
  logic [gbip_pkg::IdxW-1:0]         index;
  logic [gbip_pkg::BlockWidth-1:0]   rows  [gbip_pkg::BlockWidth];
  logic [gbip_pkg::BlockWidth-1:0]   nexts [gbip_pkg::BlockWidth];

  gbip_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .last_row_i (last_row_i),
    .busy_o     (busy_o),
    .ctrl_o     (ctrl),
    .valid_o    (product_valid_o),
    .index_o    (index),
    .final_o    (final_row_o)
  );

  for (genvar g = 0; g < gbip_pkg::BlockWidth; g++) begin : g_cell
    if (g == gbip_pkg::BlockWidth - 1) begin : g_tail
      assign nexts[g] = '0;
    end else begin : g_link
      assign nexts[g] = rows[g+1];
    end

    gbip_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .sel_i   (left_row_i[gbip_pkg::BlockWidth-1-g]),
      .right_i (right_row_i[gbip_pkg::BlockWidth-1:0]),
      .next_i  (nexts[g]),
      .row_o   (rows[g])
    );
  end

  assign product_index_o = gbip_pkg::IndexW'(index);
  assign product_row_o   = gbip_pkg::RowW'(rows[0]);

endmodule
`default_nettype wire

// ===== design/gbip_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbip_cell
// One accumulator row: XOR-accumulates the right row while its left bit is
// set, and shifts toward row zero while the product drains.
// ----------------------------------------------------------------------------
module gbip_cell (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire gbip_pkg::cell_ctrl_t                ctrl_i,
  input  wire logic                                sel_i,
  input  wire logic [gbip_pkg::BlockWidth-1:0]     right_i,
  input  wire logic [gbip_pkg::BlockWidth-1:0]     next_i,
  output logic      [gbip_pkg::BlockWidth-1:0]     row_o
);

  logic [gbip_pkg::BlockWidth-1:0] row_q, row_d;

  always_comb begin
    row_d = row_q;
    if (ctrl_i.shift_en) begin
      row_d = next_i;
    end else if (ctrl_i.acc_en && sel_i) begin
      row_d = row_q ^ right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule
`default_nettype wire

// ===== design/gbip_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbip_ctrl
// Sequencer: accumulates row pairs, then drains the product rows out of
// the cell chain one per cycle.
// ----------------------------------------------------------------------------
module gbip_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic                          last_row_i,
  output logic                               busy_o,
  output gbip_pkg::cell_ctrl_t               ctrl_o,
  output logic                               valid_o,
  output logic [gbip_pkg::IdxW-1:0]          index_o,
  output logic                               final_o
);

  gbip_pkg::state_e state_q, state_d;
  logic [gbip_pkg::IdxW-1:0] cnt_q, cnt_d;
  logic accept;
  logic cnt_end;

  assign accept  = start_i && (state_q == gbip_pkg::ST_ACCUM);
  assign cnt_end = (cnt_q == gbip_pkg::IdxW'(gbip_pkg::BlockWidth - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      gbip_pkg::ST_ACCUM: begin
        cnt_d = '0;
        if (accept && last_row_i) begin
          state_d = gbip_pkg::ST_DRAIN;
        end
      end
      gbip_pkg::ST_DRAIN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_end) begin
          state_d = gbip_pkg::ST_ACCUM;
          cnt_d   = '0;
        end
      end
      default: begin
        state_d = gbip_pkg::ST_ACCUM;
        cnt_d   = '0;
      end
    endcase
  end

  // Outputs
  always_comb begin
    busy_o          = 1'b0;
    valid_o         = 1'b0;
    final_o         = 1'b0;
    ctrl_o.acc_en   = 1'b0;
    ctrl_o.shift_en = 1'b0;
    case (state_q)
      gbip_pkg::ST_ACCUM: begin
        ctrl_o.acc_en = accept;
      end
      gbip_pkg::ST_DRAIN: begin
        busy_o          = 1'b1;
        valid_o         = 1'b1;
        final_o         = cnt_end;
        // advance the chain; zeros enter at the far end and clear it
        ctrl_o.shift_en = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

  assign index_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbip_pkg::ST_ACCUM;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o)
    else $error("result strobe outside drain");

  a_first_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> (index_o == '0))
    else $error("drain does not start at row zero");

  a_final_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_o |=> !busy_o)
    else $error("drain continues past the final row");

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_row_i) |=> (valid_o && index_o == '0))
    else $error("last transfer did not start the drain");

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for gf2_block_inner_product_top. Row pairs are streamed
// in with random sender gaps. A local model keeps its own 64-row accumulator
// and queues the 64 product rows due for each block. Every product row strobe
// is checked against the oldest queued row, field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [gbip_pkg::RowW-1:0] RowMask =
    {gbip_pkg::RowW{1'b1}} >> (gbip_pkg::RowW - gbip_pkg::BlockWidth);
  localparam int unsigned DrainCycles = gbip_pkg::BlockWidth + 6;
  localparam int unsigned StallLimit = 2000;

  typedef struct packed {
    logic [gbip_pkg::IndexW-1:0] index;
    logic [gbip_pkg::RowW-1:0]   row;
    logic                        is_final;
  } product_t;

  logic                          clk_i;
  logic                          rst_ni = 1'b0;
  logic                          start_i = 1'b0;
  logic [gbip_pkg::RowW-1:0]     left_row_i = '0;
  logic [gbip_pkg::RowW-1:0]     right_row_i = '0;
  logic                          last_row_i = 1'b0;
  logic                          busy_o;
  logic                          product_valid_o;
  logic [gbip_pkg::IndexW-1:0]   product_index_o;
  logic [gbip_pkg::RowW-1:0]     product_row_o;
  logic                          final_row_o;

  logic [gbip_pkg::RowW-1:0] acc_rows [gbip_pkg::BlockWidth];
  product_t        expected_products [$];
  bit              idle_enable = 1'b1;
  int unsigned     rows_sent = 0;
  int unsigned     blocks_sent = 0;
  int unsigned     rows_checked = 0;
  int unsigned     mismatches = 0;
  int unsigned     stall_cycles = 0;

  gf2_block_inner_product_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .left_row_i      (left_row_i),
    .right_row_i     (right_row_i),
    .last_row_i      (last_row_i),
    .product_valid_o (product_valid_o),
    .product_index_o (product_index_o),
    .product_row_o   (product_row_o),
    .final_row_o     (final_row_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [gbip_pkg::RowW-1:0] rand_row();
    return {$urandom, $urandom};
  endfunction

  // XOR the right row into every accumulator row whose left bit is set,
  // MSB first; on the last pair queue the whole product and clear.
  task automatic accumulate_row_pair(input logic [gbip_pkg::RowW-1:0] left,
                                     input logic [gbip_pkg::RowW-1:0] right,
                                     input logic last);
    logic [gbip_pkg::RowW-1:0] l;
    logic [gbip_pkg::RowW-1:0] r;
    product_t        p;
    int              k;
    l = left & RowMask;
    r = right & RowMask;
    for (k = 0; k < gbip_pkg::BlockWidth; k++) begin
      if (l[gbip_pkg::BlockWidth-1-k]) acc_rows[k] ^= r;
    end
    if (last) begin
      for (k = 0; k < gbip_pkg::BlockWidth; k++) begin
        p.index = k[gbip_pkg::IndexW-1:0];
        p.row = acc_rows[k] & RowMask;
        p.is_final = (k == gbip_pkg::BlockWidth - 1);
        expected_products.push_back(p);
        acc_rows[k] = '0;
      end
      blocks_sent++;
    end
  endtask

  // Present one row pair and hold it until the transfer happens.
  task automatic send_row_pair(input logic [gbip_pkg::RowW-1:0] left,
                               input logic [gbip_pkg::RowW-1:0] right,
                               input logic last);
    while (idle_enable && $urandom_range(0, 99) < 13) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i     <= 1'b1;
    left_row_i  <= left;
    right_row_i <= right;
    last_row_i  <= last;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    accumulate_row_pair(left, right, last);
    rows_sent++;
  endtask

  task automatic report_mismatch(input string field,
                                 input logic [gbip_pkg::RowW-1:0] exp_v,
                                 input logic [gbip_pkg::RowW-1:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s at product row %0d: expected %h, got %h",
               field, rows_checked, exp_v, act_v);
  endtask

  // Check each product row strobe against the oldest expected row.
  always @(posedge clk_i) begin
    product_t p;
    if (rst_ni && product_valid_o) begin
      if (expected_products.size() == 0) begin
        report_mismatch("unexpected row", '0, product_row_o);
      end else begin
        p = expected_products.pop_front();
        if (product_index_o !== p.index)
          report_mismatch("index", gbip_pkg::RowW'(p.index),
                          gbip_pkg::RowW'(product_index_o));
        if (product_row_o !== p.row) report_mismatch("row", p.row, product_row_o);
        if (final_row_o !== p.is_final)
          report_mismatch("final", gbip_pkg::RowW'(p.is_final),
                          gbip_pkg::RowW'(final_row_o));
      end
      rows_checked++;
    end
  end

  // Watchdog: end the run if no transfer of any kind happens for too long.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || product_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Timeout: no transfer for %0d cycles", StallLimit);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_single_pair_blocks();
    send_row_pair({gbip_pkg::RowW{1'b1}}, {gbip_pkg::RowW{1'b1}}, 1'b1);
    send_row_pair('0, {gbip_pkg::RowW{1'b1}}, 1'b1);
    send_row_pair(64'h8000_0000_0000_0000, rand_row(), 1'b1);
    send_row_pair(64'h0000_0000_0000_0001, rand_row(), 1'b1);
    send_row_pair({gbip_pkg::RowW{1'b1}}, '0, 1'b1);
  endtask

  task automatic test_short_blocks();
    send_row_pair(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0);
    send_row_pair(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_row_pair(64'hFFFF_FFFF_0000_0000, 64'h0123_4567_89AB_CDEF, 1'b1);
    // identical pairs cancel out over GF(2)
    send_row_pair(64'hDEAD_BEEF_CAFE_F00D, 64'h0F0F_0F0F_F0F0_F0F0, 1'b0);
    send_row_pair(64'hDEAD_BEEF_CAFE_F00D, 64'h0F0F_0F0F_F0F0_F0F0, 1'b1);
    for (int i = 0; i < 8; i++)
      send_row_pair(rand_row(), rand_row(), i == 7);
  endtask

  task automatic test_random_blocks(input int unsigned n_items);
    int unsigned len;
    int unsigned kind;
    int unsigned sent;
    logic [gbip_pkg::RowW-1:0] left;
    sent = 0;
    while (sent < n_items) begin
      idle_enable = !(sent >= n_items / 3 && sent < n_items / 3 + 60);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
      if (len > n_items - sent) len = n_items - sent;
      for (int i = 0; i < len; i++) begin
        kind = $urandom_range(0, 9);
        case (kind)
          0: begin
            left = '0;
          end
          1: begin
            left = {gbip_pkg::RowW{1'b1}};
          end
          2: begin
            left = 64'd1 << $urandom_range(0, gbip_pkg::RowW - 1);
          end
          default: begin
            left = rand_row();
          end
        endcase
        send_row_pair(left, rand_row(), i == len - 1);
        sent++;
      end
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    for (int k = 0; k < gbip_pkg::BlockWidth; k++) acc_rows[k] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_pair_blocks();
    test_short_blocks();
    test_random_blocks(182);
    start_i <= 1'b0;

    while (expected_products.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Streamed %0d row pairs in %0d blocks with sender gaps and a gap-free run;",
             rows_sent, blocks_sent);
    $display("checked %0d product rows, %0d field mismatches.", rows_checked, mismatches);
    if (mismatches == 0 && expected_products.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== gf2_block_inner_product_top.f =====
design/gbip_pkg.sv
design/gbip_cell.sv
design/gbip_ctrl.sv
design/gf2_block_inner_product_top.sv
bench/testbench.sv
